// File: rtl/lsc_pkg.sv
// Shared types and constants for the LFU symbol lookup cache.
package lsc_pkg;

  // Cache geometry
  localparam int unsigned ENTRIES = 2048;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned HCNT_W  = 8;

  localparam logic [HCNT_W-1:0] HIT_MAX  = 8'd255;
  localparam logic [HCNT_W-1:0] HIT_INIT = 8'd1;

  // Request modes
  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_CLEAR  = 2'd2
  } lsc_mode_e;

  // Request payload
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key_address;
    logic [63:0] fill_symbol_address;
    logic [63:0] fill_symbol_name_ref;
    logic [63:0] fill_image_name_ref;
    logic [63:0] fill_image_base;
  } lsc_req_t;

  // Response payload
  typedef struct packed {
    logic        hit;
    logic [63:0] symbol_address_out;
    logic [63:0] symbol_name_ref_out;
    logic [63:0] image_name_ref_out;
    logic [63:0] image_base_out;
  } lsc_rsp_t;

  // Tag memory word: key plus hit count
  typedef struct packed {
    logic [63:0]       key;
    logic [HCNT_W-1:0] hit_count;
  } lsc_tag_t;

  // Data memory word: the four payload words
  typedef struct packed {
    logic [63:0] symbol_address;
    logic [63:0] symbol_name_ref;
    logic [63:0] image_name_ref;
    logic [63:0] image_base;
  } lsc_data_t;

  localparam int unsigned TAG_W  = $bits(lsc_tag_t);
  localparam int unsigned DATA_W = $bits(lsc_data_t);

  // Write port bundles toward the memories
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    lsc_tag_t         data;
  } lsc_tag_wr_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    lsc_data_t        data;
  } lsc_data_wr_t;

endpackage

// File: rtl/lsc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module lsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lsc_ctrl.sv
// Request sequencer: scans the tag memory, updates hit counts and writes fills.
module lsc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request side
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  lsc_pkg::lsc_req_t    req_i,
  // response side
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output lsc_pkg::lsc_rsp_t    rsp_o,
  // tag memory
  output logic [lsc_pkg::IDX_W-1:0] tag_raddr_o,
  input  lsc_pkg::lsc_tag_t    tag_rdata_i,
  output lsc_pkg::lsc_tag_wr_t tag_wr_o,
  // data memory
  output logic [lsc_pkg::IDX_W-1:0] data_raddr_o,
  input  lsc_pkg::lsc_data_t   data_rdata_i,
  output lsc_pkg::lsc_data_wr_t data_wr_o
);
  import lsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT_RD,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  lsc_req_t           req_q, req_d;
  lsc_rsp_t           rsp_q, rsp_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]   best_q, best_d;
  logic [HCNT_W-1:0]  least_q, least_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic [CNT_W-1:0]   filled_q, filled_d;

  logic [CNT_W-1:0]   last_idx;
  logic               at_last;
  logic               key_match;
  logic               less_hit;
  logic [HCNT_W-1:0]  cnt_inc;

  // Scan bookkeeping
  assign last_idx  = filled_q - CNT_W'(1);
  assign at_last   = ({1'b0, cmp_idx_q} == last_idx);
  assign key_match = (tag_rdata_i.key == req_q.key_address);
  assign less_hit  = (tag_rdata_i.hit_count < least_q);
  assign cnt_inc   = (tag_rdata_i.hit_count < HIT_MAX) ?
                     (tag_rdata_i.hit_count + HCNT_W'(1)) : tag_rdata_i.hit_count;

  // Next state and memory port control
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    cmp_idx_d = cmp_idx_q;
    best_d    = best_q;
    least_d   = least_q;
    slot_d    = slot_q;
    filled_d  = filled_q;

    tag_raddr_o  = '0;
    data_raddr_o = cmp_idx_q;
    tag_wr_o     = '0;
    data_wr_o    = '0;

    case (state_q)
      ST_IDLE: begin
        // entry 0 is always being fetched so a scan can start next cycle
        tag_raddr_o = '0;
        if (req_valid_i) begin
          req_d     = req_i;
          rsp_d     = '0;
          cmp_idx_d = '0;
          best_d    = '0;
          least_d   = HIT_MAX;
          case (lsc_mode_e'(req_i.mode))
            MODE_LOOKUP: begin
              state_d = (filled_q == '0) ? ST_DONE : ST_SCAN;
            end
            MODE_FILL: begin
              if (filled_q < CNT_W'(ENTRIES)) begin
                slot_d   = filled_q[IDX_W-1:0];
                filled_d = filled_q + CNT_W'(1);
                state_d  = ST_WRITE;
              end else begin
                state_d = ST_SCAN;
              end
            end
            MODE_CLEAR: begin
              filled_d = '0;
              state_d  = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // tag data for cmp_idx_q arrives now; fetch the following entry
        tag_raddr_o = cmp_idx_q + IDX_W'(1);
        cmp_idx_d   = cmp_idx_q + IDX_W'(1);
        if (lsc_mode_e'(req_q.mode) == MODE_LOOKUP) begin
          if (key_match) begin
            // bump the hit count and fetch the payload
            tag_wr_o.we             = 1'b1;
            tag_wr_o.addr           = cmp_idx_q;
            tag_wr_o.data.key       = tag_rdata_i.key;
            tag_wr_o.data.hit_count = cnt_inc;
            data_raddr_o            = cmp_idx_q;
            state_d                 = ST_HIT_RD;
          end else if (at_last) begin
            state_d = ST_DONE;
          end
        end else begin
          // victim search over a full cache
          if (less_hit) begin
            least_d = tag_rdata_i.hit_count;
            best_d  = cmp_idx_q;
          end
          if (at_last) begin
            slot_d  = less_hit ? cmp_idx_q : best_q;
            state_d = ST_WRITE;
          end
        end
      end

      ST_HIT_RD: begin
        rsp_d.hit                 = 1'b1;
        rsp_d.symbol_address_out  = data_rdata_i.symbol_address;
        rsp_d.symbol_name_ref_out = data_rdata_i.symbol_name_ref;
        rsp_d.image_name_ref_out  = data_rdata_i.image_name_ref;
        rsp_d.image_base_out      = data_rdata_i.image_base;
        state_d                   = ST_DONE;
      end

      ST_WRITE: begin
        tag_wr_o.we                    = 1'b1;
        tag_wr_o.addr                  = slot_q;
        tag_wr_o.data.key              = req_q.key_address;
        tag_wr_o.data.hit_count        = HIT_INIT;
        data_wr_o.we                   = 1'b1;
        data_wr_o.addr                 = slot_q;
        data_wr_o.data.symbol_address  = req_q.fill_symbol_address;
        data_wr_o.data.symbol_name_ref = req_q.fill_symbol_name_ref;
        data_wr_o.data.image_name_ref  = req_q.fill_image_name_ref;
        data_wr_o.data.image_base      = req_q.fill_image_base;
        state_d                        = ST_DONE;
      end

      ST_DONE: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      filled_q  <= '0;
      req_q     <= '0;
      rsp_q     <= '0;
      cmp_idx_q <= '0;
      best_q    <= '0;
      least_q   <= HIT_MAX;
      slot_q    <= '0;
    end else begin
      state_q   <= state_d;
      filled_q  <= filled_d;
      req_q     <= req_d;
      rsp_q     <= rsp_d;
      cmp_idx_q <= cmp_idx_d;
      best_q    <= best_d;
      least_q   <= least_d;
      slot_q    <= slot_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_DONE);
  assign rsp_o       = rsp_q;

endmodule

// File: rtl/lfu_symbol_lookup_cache_top.sv
// A lookup scans the filled entries in order until a key match or the last one; a fill with
// free space writes the next free slot, a fill into a full cache scans every entry for the
// least hit count, and a clear resets the fill count. Requests are taken one at a time, and
// the tag memory read port scans one entry per cycle.
// Reset: fill count goes to zero and the memories are not cleared; no clearing pass.
module lfu_symbol_lookup_cache_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lsc_pkg::lsc_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lsc_pkg::lsc_rsp_t out_rsp_o
);
  import lsc_pkg::*;

  logic             rsp_valid;
  logic             rsp_ready;
  lsc_rsp_t         rsp;
  logic [IDX_W-1:0] tag_raddr;
  lsc_tag_t         tag_rdata;
  lsc_tag_wr_t      tag_wr;
  logic [IDX_W-1:0] data_raddr;
  lsc_data_t        data_rdata;
  lsc_data_wr_t     data_wr;

  logic             out_valid_q;
  lsc_rsp_t         out_rsp_q;

  // Sequencer
  lsc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_ready_o  (in_ready_o),
    .req_i        (in_req_i),
    .rsp_valid_o  (rsp_valid),
    .rsp_ready_i  (rsp_ready),
    .rsp_o        (rsp),
    .tag_raddr_o  (tag_raddr),
    .tag_rdata_i  (tag_rdata),
    .tag_wr_o     (tag_wr),
    .data_raddr_o (data_raddr),
    .data_rdata_i (data_rdata),
    .data_wr_o    (data_wr)
  );

  // Key and hit count store
  lsc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_wr.we),
    .waddr_i (tag_wr.addr),
    .wdata_i (tag_wr.data),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  // Payload store
  lsc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_wr.we),
    .waddr_i (data_wr.addr),
    .wdata_i (data_wr.data),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  // Output register
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
